// ===== src/cnpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpc_pkg
// shared types and constants of the four-neighbour peak clip unit
// ----------------------------------------------------------------------------
package cnpc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int             CFG_BITS        = 11;
    localparam [CFG_BITS-1:0]  CFG_WIDTH_RESET  = 11'd1024;
    localparam [CFG_BITS-1:0]  CFG_HEIGHT_RESET = 11'd1024;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    typedef struct packed {
        logic up;
        logic left;
        logic down;
        logic right;
    } t_nbr_ex;

endpackage

// ===== src/cnpc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpc_req_if
// request channel: pixel or drain request with valid/ready handshake
// ----------------------------------------------------------------------------
interface cnpc_req_if
    import cnpc_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    t_req                  req_type;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// ===== src/cnpc_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpc_res_if
// result channel: processed pixel with valid/ready handshake
// ----------------------------------------------------------------------------
interface cnpc_res_if
    import cnpc_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  clipped;
    logic                  last_in_frame;

    modport source (output valid, output pixel_out, output clipped, output last_in_frame,
                    input ready);
    modport sink   (input valid, input pixel_out, input clipped, input last_in_frame,
                    output ready);
endinterface

// ===== src/cnpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpc_ram
// generic single write, single read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module cnpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/cnpc_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpc_clip
// peak test of one pixel against its existing neighbours and clip to their max
// ----------------------------------------------------------------------------
module cnpc_clip
    import cnpc_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic [PIXEL_BITS-1:0] i_cur,
    input  logic [PIXEL_BITS-1:0] i_up,
    input  logic [PIXEL_BITS-1:0] i_left,
    input  logic [PIXEL_BITS-1:0] i_down,
    input  logic [PIXEL_BITS-1:0] i_right,
    input  t_nbr_ex               i_ex,
    output logic [PIXEL_BITS-1:0] o_res,
    output logic                  o_clip
);
    logic                  peak;
    logic [PIXEL_BITS-1:0] best;

    always_comb begin
        peak = 1'b1;
        best = '0;
        if (i_ex.up) begin
            if (!(i_cur > i_up)) peak = 1'b0;
            if (i_up > best) best = i_up;
        end
        if (i_ex.left) begin
            if (!(i_cur > i_left)) peak = 1'b0;
            if (i_left > best) best = i_left;
        end
        if (i_ex.down) begin
            if (!(i_cur > i_down)) peak = 1'b0;
            if (i_down > best) best = i_down;
        end
        if (i_ex.right) begin
            if (!(i_cur > i_right)) peak = 1'b0;
            if (i_right > best) best = i_right;
        end
    end

    // no neighbour at all: pass unchanged
    assign o_clip = (|i_ex) && peak;
    assign o_res  = o_clip ? best : i_cur;
endmodule

// ===== src/cross_neighbour_peak_clip_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_neighbour_peak_clip_unit
// four-neighbour peak clip over a raster-order pixel frame
// ----------------------------------------------------------------------------
// Takes one request per cycle, pixel or drain, unless a stalled result holds
// it back. The line ram read is registered in the read stage, then the compare
// and max stage writes the processed pixel into the result register. Output
// lags input by one row; once a frame is complete, drain requests flush the
// last row one pixel each. Two copies of the original row (current and right
// neighbour reads) and one processed row are held in rams of MAX_WIDTH
// entries; they need no clearing after reset. A config write restarts the
// frame position and must only be issued while the unit is idle.
// ----------------------------------------------------------------------------
module cross_neighbour_peak_clip_unit
    import cnpc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    cnpc_req_if.sink            i_req,
    cnpc_res_if.source          o_res
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    // config
    logic [CFG_BITS-1:0] r_cfg_w;
    logic [CFG_BITS-1:0] r_cfg_h;
    logic [31:0]         w_full;
    logic [31:0]         h_full;
    logic [WB-1:0]       w_eff;
    logic [HB-1:0]       h_eff;

    // frame position
    logic [AW-1:0] r_col, n_col;
    logic [HB-1:0] r_row, n_row;
    logic          r_drain, n_drain;

    // input side
    logic          acc;
    logic          is_pix;
    logic          visit;
    logic          orig_we;
    logic          col_wrap;
    t_nbr_ex       ex;
    logic          last;
    logic [AW-1:0] col_p1;

    // read stage
    logic                  r_a_vld;
    logic [AW-1:0]         r_a_col;
    t_nbr_ex               r_a_ex;
    logic [PIXEL_BITS-1:0] r_a_down;
    logic                  r_a_last;
    logic                  a_move;

    // result stage
    logic                  r_b_vld;
    logic [PIXEL_BITS-1:0] r_b_pix;
    logic                  r_b_clip;
    logic                  r_b_last;
    logic [PIXEL_BITS-1:0] r_prev;

    logic [PIXEL_BITS-1:0] cur_q;
    logic [PIXEL_BITS-1:0] right_q;
    logic [PIXEL_BITS-1:0] up_q;
    logic [PIXEL_BITS-1:0] up_val;
    logic [PIXEL_BITS-1:0] res;
    logic                  clip;

    // effective dimensions: zero acts as one, clamp to the limit
    always_comb begin
        w_full = 32'(r_cfg_w);
        if (r_cfg_w == '0) begin
            w_full = 32'd1;
        end else if (w_full > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end
        h_full = 32'(r_cfg_h);
        if (r_cfg_h == '0) begin
            h_full = 32'd1;
        end else if (h_full > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end
    end

    assign w_eff = w_full[WB-1:0];
    assign h_eff = h_full[HB-1:0];

    assign a_move      = r_a_vld && (!r_b_vld || o_res.ready);
    assign i_req.ready = !r_a_vld || a_move;
    assign acc         = i_req.valid && i_req.ready;
    assign is_pix      = (i_req.req_type == REQ_PIXEL);

    assign visit    = acc && ((is_pix && !r_drain && (r_row != '0)) || (!is_pix && r_drain));
    assign orig_we  = acc && is_pix && !r_drain;
    assign col_wrap = (32'(r_col) + 32'd1) >= 32'(w_eff);
    assign col_p1   = r_col + AW'(1);

    always_comb begin
        ex.up    = r_drain ? (h_eff > HB'(1)) : (r_row > HB'(1));
        ex.left  = (r_col != '0);
        ex.down  = !r_drain;
        ex.right = !col_wrap;
        last     = r_drain && col_wrap;
    end

    // frame position update
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        if (orig_we) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = r_row + HB'(1);
                if ((32'(r_row) + 32'd1) >= 32'(h_eff)) begin
                    n_drain = 1'b1;
                end
            end else begin
                n_col = col_p1;
            end
        end else if (acc && !is_pix && r_drain) begin
            if (col_wrap) begin
                n_col   = '0;
                n_row   = '0;
                n_drain = 1'b0;
            end else begin
                n_col = col_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_WIDTH_RESET;
            r_cfg_h <= CFG_HEIGHT_RESET;
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
                r_col   <= '0;
                r_row   <= '0;
                r_drain <= 1'b0;
            end else begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_drain <= n_drain;
            end
            if (i_req.ready) begin
                r_a_vld <= visit;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (visit) begin
            r_a_col  <= r_col;
            r_a_ex   <= ex;
            r_a_down <= i_req.pixel_in;
            r_a_last <= last;
        end
        if (a_move) begin
            r_b_pix  <= res;
            r_b_clip <= clip;
            r_b_last <= r_a_last;
            r_prev   <= res;
        end
    end

    cnpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_orig_cur (
        .i_clk   (i_clk),
        .i_we    (orig_we),
        .i_waddr (r_col),
        .i_wdata (i_req.pixel_in),
        .i_re    (visit),
        .i_raddr (r_col),
        .o_rdata (cur_q)
    );

    cnpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_orig_right (
        .i_clk   (i_clk),
        .i_we    (orig_we),
        .i_waddr (r_col),
        .i_wdata (i_req.pixel_in),
        .i_re    (visit),
        .i_raddr (col_p1),
        .o_rdata (right_q)
    );

    cnpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_proc (
        .i_clk   (i_clk),
        .i_we    (a_move),
        .i_waddr (r_a_col),
        .i_wdata (res),
        .i_re    (visit),
        .i_raddr (r_col),
        .o_rdata (up_q)
    );

    // single column frame: the pixel above is the previous result
    assign up_val = (w_eff == WB'(1)) ? r_prev : up_q;

    cnpc_clip #(.PIXEL_BITS(PIXEL_BITS)) u_clip (
        .i_cur   (cur_q),
        .i_up    (up_val),
        .i_left  (r_prev),
        .i_down  (r_a_down),
        .i_right (right_q),
        .i_ex    (r_a_ex),
        .o_res   (res),
        .o_clip  (clip)
    );

    assign o_res.valid         = r_b_vld;
    assign o_res.pixel_out     = r_b_pix;
    assign o_res.clipped       = r_b_clip;
    assign o_res.last_in_frame = r_b_last;
endmodule

// ===== src/cnpc_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpc_chk
// port level checks of the peak clip unit, bound to the top level
// ----------------------------------------------------------------------------
module cnpc_chk
    import cnpc_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic [PIXEL_BITS-1:0] i_res_pixel,
    input logic                  i_res_clipped,
    input logic                  i_res_last
);
    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_pixel)
            && $stable(i_res_clipped) && $stable(i_res_last))
        else $error("stalled result changed");

    // an empty result register never back-pressures the request side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_req_ready)
        else $error("request blocked with empty result register");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a fresh result needs an earlier taken request, a blocked request side or an earlier valid result
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) && $past(i_rst_n) && $past(i_rst_n, 2)
            |-> $past(i_req_valid && i_req_ready, 2) || $past(!i_req_ready)
                || $past(!i_req_ready, 2) || $past(i_res_valid, 2))
        else $error("result without a request");
endmodule

bind cross_neighbour_peak_clip_unit cnpc_chk #(.PIXEL_BITS(PIXEL_BITS)) u_cnpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_pixel   (o_res.pixel_out),
    .i_res_clipped (o_res.clipped),
    .i_res_last    (o_res.last_in_frame)
);
